@@ sv/hpol_pkg.sv @@
// Shared types, codes and constants of the proximal overlap and learning block.
`default_nettype none

package hpol_pkg;

  // Default structure sizes
  localparam int unsigned NumSynapsesDef = 64;
  localparam int unsigned InputBitsDef   = 1024;
  localparam int unsigned PermOneDef     = 4096;

  // Fixed field widths
  localparam int unsigned KindW      = 2;
  localparam int unsigned SlotW      = 6;
  localparam int unsigned SrcW       = 10;
  localparam int unsigned PermFieldW = 13;
  localparam int unsigned WordIdxW   = 4;
  localparam int unsigned WordW      = 64;
  localparam int unsigned BitPosW    = 6;
  localparam int unsigned CountW     = 7;

  // Configuration port
  localparam int unsigned ApbAw = 5;
  localparam int unsigned ApbDw = 32;

  localparam logic [PermFieldW-1:0] ThresholdRst = 13'd819;
  localparam logic [PermFieldW-1:0] IncrementRst = 13'd205;
  localparam logic [PermFieldW-1:0] DecrementRst = 13'd41;
  localparam logic [CountW-1:0]     MinOverlapRst = 7'd2;
  localparam logic [CountW-1:0]     ActiveRst     = 7'd64;

  typedef enum logic [KindW-1:0] {
    REQ_WR_SYN  = 2'd0,
    REQ_WR_WORD = 2'd1,
    REQ_OVERLAP = 2'd2,
    REQ_LEARN   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_INCREMENT = 3'd1,
    REG_DECREMENT = 3'd2,
    REG_MIN_OVL   = 3'd3,
    REG_ACTIVE    = 3'd4
  } reg_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [PermFieldW-1:0] connected_threshold;
    logic [PermFieldW-1:0] perm_increment;
    logic [PermFieldW-1:0] perm_decrement;
    logic [CountW-1:0]     min_overlap;
    logic [CountW-1:0]     active_synapses;
  } cfg_t;

  // Per-synapse result of the update stage
  typedef struct packed {
    logic hit;   // overlap request, connected before it and input bit set
    logic conn;  // connected after the request
  } upd_t;

endpackage

`default_nettype wire

@@ sv/hpol_if.sv @@
// Request and response channel interfaces.
`default_nettype none

interface hpol_req_if;
  import hpol_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [KindW-1:0]      req_type;
  logic [SlotW-1:0]      slot;
  logic [SrcW-1:0]       source_bit;
  logic [PermFieldW-1:0] permanence;
  logic [WordIdxW-1:0]   word_index;
  logic [WordW-1:0]      word_data;

  modport source (
    output valid, req_type, slot, source_bit, permanence, word_index, word_data,
    input  ready
  );
  modport sink (
    input  valid, req_type, slot, source_bit, permanence, word_index, word_data,
    output ready
  );
endinterface

interface hpol_rsp_if;
  import hpol_pkg::*;

  logic              valid;
  logic              ready;
  logic [CountW-1:0] overlap;
  logic [CountW-1:0] connected_count;
  logic [KindW-1:0]  resp_kind;

  modport source (
    output valid, overlap, connected_count, resp_kind,
    input  ready
  );
  modport sink (
    input  valid, overlap, connected_count, resp_kind,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/hpol_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none

module hpol_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/hpol_regs.sv @@
// APB configuration register bank.
`default_nettype none

module hpol_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [hpol_pkg::ApbAw-1:0] paddr,
  input  wire logic [hpol_pkg::ApbDw-1:0] pwdata,
  output logic      [hpol_pkg::ApbDw-1:0] prdata,
  output logic                            pready,
  output hpol_pkg::cfg_t                  cfg_o
);
  import hpol_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] reg_idx;

  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.connected_threshold <= ThresholdRst;
      cfg_q.perm_increment      <= IncrementRst;
      cfg_q.perm_decrement      <= DecrementRst;
      cfg_q.min_overlap         <= MinOverlapRst;
      cfg_q.active_synapses     <= ActiveRst;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_THRESHOLD: cfg_q.connected_threshold <= pwdata[PermFieldW-1:0];
        REG_INCREMENT: cfg_q.perm_increment      <= pwdata[PermFieldW-1:0];
        REG_DECREMENT: cfg_q.perm_decrement      <= pwdata[PermFieldW-1:0];
        REG_MIN_OVL:   cfg_q.min_overlap         <= pwdata[CountW-1:0];
        REG_ACTIVE:    cfg_q.active_synapses     <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_THRESHOLD: prdata = ApbDw'(cfg_q.connected_threshold);
      REG_INCREMENT: prdata = ApbDw'(cfg_q.perm_increment);
      REG_DECREMENT: prdata = ApbDw'(cfg_q.perm_decrement);
      REG_MIN_OVL:   prdata = ApbDw'(cfg_q.min_overlap);
      REG_ACTIVE:    prdata = ApbDw'(cfg_q.active_synapses);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ sv/hpol_upd.sv @@
// Per-synapse permanence update and connected/overlap flags.
`default_nettype none

module hpol_upd #(
  parameter int unsigned PERM_ONE = hpol_pkg::PermOneDef,
  parameter int unsigned PERM_W   = $clog2(PERM_ONE + 1)
) (
  input  wire hpol_pkg::cfg_t     cfg_i,
  input  wire hpol_pkg::req_e     kind_i,
  input  wire logic [PERM_W-1:0]  perm_i,
  input  wire logic               bit_i,
  output logic      [PERM_W-1:0]  perm_o,
  output hpol_pkg::upd_t          flags_o
);
  import hpol_pkg::*;

  localparam int unsigned EW = ((PERM_W > PermFieldW) ? PERM_W : PermFieldW) + 1;

  logic [EW-1:0] perm_e, thr_e, one_e, inc_e, dec_e, sum_e, next_e;
  logic          conn_old;

  always_comb begin
    perm_e = EW'(perm_i);
    thr_e  = EW'(cfg_i.connected_threshold);
    one_e  = EW'(PERM_ONE);
    inc_e  = EW'(cfg_i.perm_increment);
    dec_e  = EW'(cfg_i.perm_decrement);
    sum_e  = perm_e + inc_e;

    if (kind_i != REQ_LEARN) begin
      next_e = perm_e;
    end else if (bit_i) begin
      next_e = (sum_e > one_e) ? one_e : sum_e;
    end else begin
      next_e = (perm_e > dec_e) ? perm_e - dec_e : '0;
    end

    conn_old      = perm_e >= thr_e;
    flags_o.hit   = (kind_i == REQ_OVERLAP) && conn_old && bit_i;
    flags_o.conn  = next_e >= thr_e;
    perm_o        = next_e[PERM_W-1:0];
  end

endmodule

`default_nettype wire

@@ sv/htm_proximal_overlap_learn.sv @@
// Proximal overlap and learning block: request sequencer, table walk and response register.
// Requests are taken one at a time, only in idle and once the previous response is loaded;
// each walks n = min(active, slots) slots of the synapse table, one slot per cycle
// through its single read port, bitmap read and write-back pipelined two stages behind.
// Reset: registers take their reset values; the input bitmap is cleared one word per cycle,
// with no request accepted meanwhile. Synapses are not cleared.
`default_nettype none

module htm_proximal_overlap_learn #(
  parameter int unsigned NUM_SYNAPSES = hpol_pkg::NumSynapsesDef,
  parameter int unsigned INPUT_BITS   = hpol_pkg::InputBitsDef,
  parameter int unsigned PERM_ONE     = hpol_pkg::PermOneDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  hpol_req_if.sink                        req_i,
  hpol_rsp_if.source                      rsp_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [hpol_pkg::ApbAw-1:0] paddr,
  input  wire logic [hpol_pkg::ApbDw-1:0] pwdata,
  output logic      [hpol_pkg::ApbDw-1:0] prdata,
  output logic                            pready
);
  import hpol_pkg::*;

  localparam int unsigned WORD_COUNT = (INPUT_BITS + 63) / 64;
  localparam int unsigned WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int unsigned SYN_AW     = (NUM_SYNAPSES > 1) ? $clog2(NUM_SYNAPSES) : 1;
  localparam int unsigned CNT_W      = $clog2(NUM_SYNAPSES + 1);
  localparam int unsigned CW         = (CNT_W > CountW) ? CNT_W : CountW;
  localparam int unsigned PERM_W     = $clog2(PERM_ONE + 1);
  localparam int unsigned SYN_W      = SrcW + PERM_W;
  localparam int unsigned EW         = ((PERM_W > PermFieldW) ? PERM_W : PermFieldW) + 1;

  cfg_t   cfg;
  state_e state_q, state_d;

  logic   req_ready, start, rsp_load, walk_done, issue, clr_last, acc;
  req_e   req_kind;
  logic   acc_syn, acc_word;

  logic [WORD_AW-1:0] clr_q;
  logic [CNT_W-1:0]   rd_idx_q, n_q, n_d;
  req_e               kind_q;
  logic [CW-1:0]      conn_cnt_q, ovl_cnt_q;

  // Pipeline stage 1: synapse read data returning
  logic              s1_v_q;
  logic [SYN_AW-1:0] s1_idx_q;
  // Pipeline stage 2: bitmap read data returning
  logic               s2_v_q;
  logic [SYN_AW-1:0]  s2_idx_q;
  logic [SrcW-1:0]    s2_src_q;
  logic [PERM_W-1:0]  s2_perm_q;
  logic [BitPosW-1:0] s2_bitpos_q;
  logic               s2_inr_q;

  logic              rsp_valid_q;
  logic [CountW-1:0] rsp_ovl_q, rsp_conn_q;
  req_e              rsp_kind_q;

  // Memory ports
  logic               syn_we;
  logic [SYN_AW-1:0]  syn_waddr;
  logic [SYN_W-1:0]   syn_wdata, syn_rdata;
  logic               bm_we;
  logic [WORD_AW-1:0] bm_waddr, bm_raddr;
  logic [WordW-1:0]   bm_wdata, bm_rdata;

  logic [SrcW-1:0]   syn_src;
  logic [PERM_W-1:0] syn_perm, perm_wr, perm_new;
  logic              syn_inr, cur_bit;
  upd_t              flags;

  hpol_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hpol_ram #(.WIDTH(SYN_W), .DEPTH(NUM_SYNAPSES), .AW(SYN_AW)) u_syn_ram (
    .clk_i   (clk_i),
    .we_i    (syn_we),
    .waddr_i (syn_waddr),
    .wdata_i (syn_wdata),
    .raddr_i (rd_idx_q[SYN_AW-1:0]),
    .rdata_o (syn_rdata)
  );

  hpol_ram #(.WIDTH(WordW), .DEPTH(WORD_COUNT), .AW(WORD_AW)) u_bm_ram (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .raddr_i (bm_raddr),
    .rdata_o (bm_rdata)
  );

  hpol_upd #(.PERM_ONE(PERM_ONE), .PERM_W(PERM_W)) u_upd (
    .cfg_i   (cfg),
    .kind_i  (kind_q),
    .perm_i  (s2_perm_q),
    .bit_i   (cur_bit),
    .perm_o  (perm_new),
    .flags_o (flags)
  );

  // Request decode
  assign req_kind    = req_e'(req_i.req_type);
  assign req_i.ready = req_ready;
  assign acc         = req_i.valid && req_ready;
  assign acc_syn     = acc && (req_kind == REQ_WR_SYN) && (32'(req_i.slot) < NUM_SYNAPSES);
  assign acc_word    = acc && (req_kind == REQ_WR_WORD) && (32'(req_i.word_index) < WORD_COUNT);
  assign perm_wr     = (EW'(req_i.permanence) > EW'(PERM_ONE)) ? PERM_W'(PERM_ONE)
                                                                : PERM_W'(req_i.permanence);
  assign n_d = (32'(cfg.active_synapses) > NUM_SYNAPSES) ? CNT_W'(NUM_SYNAPSES)
                                                         : CNT_W'(cfg.active_synapses);

  assign clr_last  = clr_q == WORD_AW'(WORD_COUNT - 1);
  assign issue     = (state_q == ST_WALK) && (rd_idx_q != n_q);
  assign walk_done = (rd_idx_q == n_q) && !s1_v_q && !s2_v_q;

  // Stage 1 decode of the synapse entry
  assign syn_src  = syn_rdata[SYN_W-1 -: SrcW];
  assign syn_perm = syn_rdata[PERM_W-1:0];
  assign syn_inr  = 32'(syn_src) < INPUT_BITS;
  assign bm_raddr = WORD_AW'(syn_src >> BitPosW);

  assign cur_bit = s2_inr_q && bm_rdata[s2_bitpos_q];

  // Synapse table: request write or learn write-back, never in the same cycle
  assign syn_we    = acc_syn || (s2_v_q && (kind_q == REQ_LEARN));
  assign syn_waddr = acc_syn ? SYN_AW'(req_i.slot) : s2_idx_q;
  assign syn_wdata = acc_syn ? {req_i.source_bit, perm_wr} : {s2_src_q, perm_new};

  // Bitmap: clearing pass after reset or word write
  assign bm_we    = (state_q == ST_CLEAR) || acc_word;
  assign bm_waddr = (state_q == ST_CLEAR) ? clr_q : WORD_AW'(req_i.word_index);
  assign bm_wdata = (state_q == ST_CLEAR) ? '0 : req_i.word_data;

  always_comb begin
    state_d   = state_q;
    req_ready = 1'b0;
    start     = 1'b0;
    rsp_load  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_i.valid) begin
          start   = 1'b1;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_done) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      rd_idx_q    <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (start) begin
        rd_idx_q <= '0;
      end else if (issue) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      kind_q     <= req_kind;
      n_q        <= n_d;
      conn_cnt_q <= '0;
      ovl_cnt_q  <= '0;
    end else if (s2_v_q) begin
      conn_cnt_q <= conn_cnt_q + CW'(flags.conn);
      ovl_cnt_q  <= ovl_cnt_q + CW'(flags.hit);
    end
    s1_idx_q    <= rd_idx_q[SYN_AW-1:0];
    s2_idx_q    <= s1_idx_q;
    s2_src_q    <= syn_src;
    s2_perm_q   <= syn_perm;
    s2_bitpos_q <= syn_src[BitPosW-1:0];
    s2_inr_q    <= syn_inr;
    if (rsp_load) begin
      rsp_kind_q <= kind_q;
      rsp_conn_q <= conn_cnt_q[CountW-1:0];
      rsp_ovl_q  <= ((kind_q == REQ_OVERLAP) && (ovl_cnt_q >= CW'(cfg.min_overlap)))
                    ? ovl_cnt_q[CountW-1:0] : '0;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.overlap         = rsp_ovl_q;
  assign rsp_o.connected_count = rsp_conn_q;
  assign rsp_o.resp_kind       = rsp_kind_q;

  // The walk pipeline only carries slots while a walk is in progress
  a_pipe_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q || s2_v_q) |-> (state_q == ST_WALK))
    else $error("table walk pipeline active outside walk");

  a_conn_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP) |-> (conn_cnt_q <= CW'(n_q)))
    else $error("connected count exceeds walked slots");

  a_ovl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RESP) && (kind_q == REQ_OVERLAP)) |-> (ovl_cnt_q <= conn_cnt_q))
    else $error("overlap exceeds connected count");

  a_ovl_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_kind_q != REQ_OVERLAP)) |-> (rsp_ovl_q == '0))
    else $error("nonzero overlap on non-overlap transaction");

endmodule

`default_nettype wire

@@ dv/tb_htm_proximal_overlap_learn.sv @@
// Testbench of the proximal overlap and learning block: predictor, stimulus and result checks.
`default_nettype none

module tb_htm_proximal_overlap_learn;
  import hpol_pkg::*;

  localparam int NumSlots  = NumSynapsesDef;
  localparam int NumWords  = InputBitsDef / WordW;
  localparam int PermOne   = PermOneDef;
  localparam int PermMax   = (1 << PermFieldW) - 1;
  localparam int CycleCap  = 400000;
  localparam int LongHold  = 300;
  localparam int NumPhases = 8;
  localparam int PhaseReqs = 55;

  typedef struct {
    req_e                  kind;
    logic [SlotW-1:0]      slot;
    logic [SrcW-1:0]       source_bit;
    logic [PermFieldW-1:0] permanence;
    logic [WordIdxW-1:0]   word_index;
    logic [WordW-1:0]      word_data;
  } req_t;

  typedef struct {
    logic [CountW-1:0] overlap;
    logic [CountW-1:0] connected_count;
    logic [KindW-1:0]  kind;
  } rsp_t;

  // Predicts each response from a private copy of the tables and settings.
  class overlap_scoreboard;
    logic [PermFieldW-1:0] thresh, incr, decr;
    logic [CountW-1:0]     min_ovl, act_slots;
    logic [SrcW-1:0]       src [NumSlots];
    logic [PermFieldW-1:0] perm [NumSlots];
    logic [WordW-1:0]      bitmap [NumWords];
    rsp_t                  expq [$];
    int                    failures;

    function new();
      thresh    = ThresholdRst;
      incr      = IncrementRst;
      decr      = DecrementRst;
      min_ovl   = MinOverlapRst;
      act_slots = ActiveRst;
      failures  = 0;
      foreach (bitmap[w]) bitmap[w] = '0;
      foreach (perm[i]) begin
        perm[i] = '0;
        src[i]  = '0;
      end
    endfunction

    function void set_reg(reg_e r, logic [ApbDw-1:0] v);
      case (r)
        REG_THRESHOLD: thresh    = v[PermFieldW-1:0];
        REG_INCREMENT: incr      = v[PermFieldW-1:0];
        REG_DECREMENT: decr      = v[PermFieldW-1:0];
        REG_MIN_OVL:   min_ovl   = v[CountW-1:0];
        REG_ACTIVE:    act_slots = v[CountW-1:0];
        default: ;
      endcase
    endfunction

    function int used_slots();
      return (act_slots > NumSlots) ? NumSlots : int'(act_slots);
    endfunction

    function bit input_set(logic [SrcW-1:0] idx);
      return bitmap[idx[SrcW-1:BitPosW]][idx[BitPosW-1:0]];
    endfunction

    function int pending();
      return expq.size();
    endfunction

    function void note_request(req_t r);
      rsp_t want;
      int   ovl, conn, p, n;
      ovl = 0;
      conn = 0;
      n = used_slots();
      case (r.kind)
        REQ_WR_SYN: begin
          src[r.slot]  = r.source_bit;
          perm[r.slot] = (r.permanence > PermOne) ? PermOne[PermFieldW-1:0] : r.permanence;
        end
        REQ_WR_WORD: bitmap[r.word_index] = r.word_data;
        REQ_OVERLAP: begin
          for (int i = 0; i < n; i++)
            if (perm[i] >= thresh && input_set(src[i])) ovl++;
          if (ovl < min_ovl) ovl = 0;
        end
        default: begin
          for (int i = 0; i < n; i++) begin
            p = int'(perm[i]);
            if (input_set(src[i])) begin
              p = p + incr;
              if (p > PermOne) p = PermOne;
            end else begin
              p = (p > decr) ? p - decr : 0;
            end
            perm[i] = p[PermFieldW-1:0];
          end
        end
      endcase
      for (int i = 0; i < n; i++)
        if (perm[i] >= thresh) conn++;
      want.overlap         = ovl[CountW-1:0];
      want.connected_count = conn[CountW-1:0];
      want.kind            = r.kind;
      expq.push_back(want);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expq.size() == 0) begin
        $display("%0t: unexpected transaction: overlap %0d connected %0d kind %0d",
                 $time, got.overlap, got.connected_count, got.kind);
        failures++;
        return;
      end
      want = expq.pop_front();
      if (got.overlap !== want.overlap) begin
        $display("%0t: overlap expected %0d actual %0d", $time, want.overlap, got.overlap);
        failures++;
      end
      if (got.connected_count !== want.connected_count) begin
        $display("%0t: connected_count expected %0d actual %0d",
                 $time, want.connected_count, got.connected_count);
        failures++;
      end
      if (got.kind !== want.kind) begin
        $display("%0t: resp_kind expected %0d actual %0d", $time, want.kind, got.kind);
        failures++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             psel, penable, pwrite;
  logic [ApbAw-1:0] paddr;
  logic [ApbDw-1:0] pwdata;
  logic [ApbDw-1:0] prdata;
  logic             pready;

  hpol_req_if req_bus ();
  hpol_rsp_if rsp_bus ();

  htm_proximal_overlap_learn dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_bus),
    .rsp_o   (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  overlap_scoreboard sb;
  bit                slot_loaded [NumSlots];
  bit                quiet;
  bit                hold_pending;
  bit                hold_taken;
  int                stall_left;
  int                cycles;

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleCap) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Response side back-pressure: random short stalls plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_pending && !hold_taken) begin
      hold_taken = 1'b1;
      stall_left = LongHold;
    end
    if (stall_left > 0) begin
      stall_left--;
      rsp_bus.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 7);
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    req_t seen;
    rsp_t got;
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready) begin
        seen.kind       = req_e'(req_bus.req_type);
        seen.slot       = req_bus.slot;
        seen.source_bit = req_bus.source_bit;
        seen.permanence = req_bus.permanence;
        seen.word_index = req_bus.word_index;
        seen.word_data  = req_bus.word_data;
        sb.note_request(seen);
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        got.overlap         = rsp_bus.overlap;
        got.connected_count = rsp_bus.connected_count;
        got.kind            = rsp_bus.resp_kind;
        sb.check_response(got);
      end
    end
  end

  function automatic req_t noise_item(req_e k);
    req_t r;
    r.kind       = k;
    r.slot       = SlotW'($urandom);
    r.source_bit = SrcW'($urandom);
    r.word_index = WordIdxW'($urandom);
    r.word_data  = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       r.permanence = '0;
      1:       r.permanence = PermFieldW'(PermOne);
      2:       r.permanence = PermFieldW'($urandom_range(PermOne + 1, PermMax));
      3:       r.permanence = sb.thresh;
      4:       r.permanence = sb.thresh - 1'b1;
      default: r.permanence = PermFieldW'($urandom_range(0, PermOne));
    endcase
    return r;
  endfunction

  function automatic req_t random_item();
    req_t             r;
    int               pick;
    logic [WordW-1:0] a, b;
    pick = $urandom_range(0, 99);
    if (pick < 30)      r = noise_item(REQ_WR_SYN);
    else if (pick < 55) r = noise_item(REQ_WR_WORD);
    else if (pick < 80) r = noise_item(REQ_OVERLAP);
    else                r = noise_item(REQ_LEARN);
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    if (r.kind == REQ_WR_WORD) begin
      case ($urandom_range(0, 4))
        0:       r.word_data = '1;
        1:       r.word_data = '0;
        2:       r.word_data = a & b;
        3:       r.word_data = a | b;
        default: r.word_data = a;
      endcase
    end
    // walks must only touch loaded slots: load the lowest missing one instead
    if (r.kind == REQ_OVERLAP || r.kind == REQ_LEARN) begin
      for (int i = sb.used_slots() - 1; i >= 0; i--) begin
        if (!slot_loaded[i]) begin
          r.kind = REQ_WR_SYN;
          r.slot = SlotW'(i);
        end
      end
    end
    return r;
  endfunction

  task automatic send_request(input req_t r);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    req_bus.valid      <= 1'b1;
    req_bus.req_type   <= r.kind;
    req_bus.slot       <= r.slot;
    req_bus.source_bit <= r.source_bit;
    req_bus.permanence <= r.permanence;
    req_bus.word_index <= r.word_index;
    req_bus.word_data  <= r.word_data;
    if (r.kind == REQ_WR_SYN) slot_loaded[r.slot] = 1'b1;
    do @(posedge clk_i); while (!req_bus.ready);
  endtask

  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic apb_beat(input reg_e r, input logic [ApbDw-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(r, v);
  endtask

  task automatic load_settings(input logic [PermFieldW-1:0] thr, inc, dec,
                               input logic [CountW-1:0] min_ovl, act);
    apb_beat(REG_THRESHOLD, ApbDw'(thr));
    apb_beat(REG_INCREMENT, ApbDw'(inc));
    apb_beat(REG_DECREMENT, ApbDw'(dec));
    apb_beat(REG_MIN_OVL, ApbDw'(min_ovl));
    apb_beat(REG_ACTIVE, ApbDw'(act));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    logic [PermFieldW-1:0] thr_set [NumPhases];
    logic [PermFieldW-1:0] inc_set [NumPhases];
    logic [PermFieldW-1:0] dec_set [NumPhases];
    logic [CountW-1:0]     min_set [NumPhases];
    logic [CountW-1:0]     act_set [NumPhases];
    req_t                  r;
    thr_set = '{819, 0, 4096, 8191, 2048, 0, 500, 819};
    inc_set = '{205, 4096, 1, 8191, 300, 0, 1, 205};
    dec_set = '{41, 4096, 1, 8191, 300, 0, 8191, 41};
    min_set = '{2, 0, 64, 127, 1, 0, 5, 2};
    act_set = '{64, 64, 64, 127, 0, 0, 1, 64};
    thr_set[5] = PermFieldW'($urandom_range(0, PermOne));
    inc_set[5] = PermFieldW'($urandom_range(0, PermOne));
    dec_set[5] = PermFieldW'($urandom_range(0, PermOne));
    min_set[5] = CountW'($urandom_range(0, NumSlots));
    act_set[5] = CountW'($urandom_range(0, NumSlots));

    sb = new();
    rst_ni             <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    req_bus.valid      <= 1'b0;
    req_bus.req_type   <= REQ_WR_SYN;
    req_bus.slot       <= '0;
    req_bus.source_bit <= '0;
    req_bus.permanence <= '0;
    req_bus.word_index <= '0;
    req_bus.word_data  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: four live slots, saturating and exact-threshold permanences, edge bits.
    load_settings(ThresholdRst, IncrementRst, DecrementRst, MinOverlapRst, 7'd4);
    r = noise_item(REQ_WR_SYN);
    r.slot = 0; r.source_bit = 0; r.permanence = PermFieldW'(PermMax);
    send_request(r);
    r = noise_item(REQ_WR_SYN);
    r.slot = 1; r.source_bit = SrcW'(InputBitsDef - 1); r.permanence = PermFieldW'(PermOne);
    send_request(r);
    r = noise_item(REQ_WR_SYN);
    r.slot = 2; r.source_bit = SrcW'(WordW); r.permanence = '0;
    send_request(r);
    r = noise_item(REQ_WR_SYN);
    r.slot = 3; r.source_bit = 5; r.permanence = ThresholdRst;
    send_request(r);
    r = noise_item(REQ_WR_SYN);
    r.slot = SlotW'(NumSlots - 1); r.source_bit = SrcW'(InputBitsDef - 1);
    r.permanence = ThresholdRst - 1'b1;
    send_request(r);
    r = noise_item(REQ_WR_WORD);
    r.word_index = 0; r.word_data = '1;
    send_request(r);
    r = noise_item(REQ_WR_WORD);
    r.word_index = WordIdxW'(NumWords - 1); r.word_data = {1'b1, {(WordW - 1){1'b0}}};
    send_request(r);
    send_request(noise_item(REQ_OVERLAP));
    send_request(noise_item(REQ_LEARN));
    send_request(noise_item(REQ_OVERLAP));
    r = noise_item(REQ_WR_WORD);
    r.word_index = 0; r.word_data = '0;
    send_request(r);
    r = noise_item(REQ_WR_WORD);
    r.word_index = 1; r.word_data = 64'd1;
    send_request(r);
    send_request(noise_item(REQ_LEARN));
    send_request(noise_item(REQ_OVERLAP));
    r = noise_item(REQ_WR_WORD);
    r.word_index = WordIdxW'(NumWords - 1); r.word_data = '0;
    send_request(r);
    send_request(noise_item(REQ_LEARN));
    send_request(noise_item(REQ_OVERLAP));

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      load_settings(thr_set[ph], inc_set[ph], dec_set[ph], min_set[ph], act_set[ph]);
      if (ph == 2) hold_pending = 1'b1;
      if (ph == NumPhases - 1) quiet = 1'b1;
      for (int k = 0; k < PhaseReqs; k++) begin
        send_request(random_item());
        // sender pause with the pipeline fully drained
        if (ph == 4 && k == PhaseReqs / 2) wait_drained();
      end
    end

    wait_drained();
    repeat (80) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
